@@ rtl/utf16_to_utf8_encoder_macros.svh @@
// Assertion macros shared by the encoder's RTL files.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication under reset.
`define U2U8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u8 same-cycle check failed");

// Next-cycle implication under reset.
`define U2U8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2u8 next-cycle check failed");

`endif

@@ rtl/u2u8_pkg.sv @@
// Types, constants and byte-forming functions for the UTF-16 to UTF-8 encoder.
package u2u8_pkg;

    localparam logic [15:0] HIGH_MIN    = 16'hD800;
    localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
    localparam logic [15:0] LOW_MIN     = 16'hDC00;
    localparam logic [15:0] LOW_MAX     = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] REPL_CP     = 21'h0FFFD;
    localparam logic [20:0] LIM_1BYTE   = 21'h80;
    localparam logic [20:0] LIM_2BYTE   = 21'h800;
    localparam logic [7:0]  LEAD_2      = 8'hC0;
    localparam logic [7:0]  LEAD_3      = 8'hE0;
    localparam logic [7:0]  LEAD_4      = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;

    localparam logic [2:0]  LEN_NONE    = 3'd0;
    localparam logic [2:0]  LEN_1       = 3'd1;
    localparam logic [2:0]  LEN_2       = 3'd2;
    localparam logic [2:0]  LEN_3       = 3'd3;
    localparam logic [2:0]  LEN_4       = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    // One request of work for the back end.
    typedef struct packed {
        logic        pre;   // U+FFFD for a dropped high surrogate goes first
        logic [2:0]  len;   // bytes of cp, zero when none
        logic [20:0] cp;
        logic        last;  // request ends the string
    } entry_t;

    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] n;
        begin
            if (cp < LIM_1BYTE)
                n = LEN_1;
            else if (cp < LIM_2BYTE)
                n = LEN_2;
            else if (cp < SUPP_BASE)
                n = LEN_3;
            else
                n = LEN_4;
            return n;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [2:0]  len,
                                            input logic [1:0]  j);
        logic [7:0] b;
        begin
            b = CONT | {2'b00, cp[5:0]};
            unique case (len)
                LEN_1: b = {1'b0, cp[6:0]};
                LEN_2: b = (j == 2'd0) ? (LEAD_2 | {3'b000, cp[10:6]})
                                       : (CONT | {2'b00, cp[5:0]});
                LEN_3:
                begin
                    case (j)
                        2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
                        2'd1:    b = CONT | {2'b00, cp[11:6]};
                        default: b = CONT | {2'b00, cp[5:0]};
                    endcase
                end
                LEN_4:
                begin
                    case (j)
                        2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
                        2'd1:    b = CONT | {2'b00, cp[17:12]};
                        2'd2:    b = CONT | {2'b00, cp[11:6]};
                        default: b = CONT | {2'b00, cp[5:0]};
                    endcase
                end
                default: b = CONT | {2'b00, cp[5:0]};
            endcase
            return b;
        end
    endfunction

endpackage

@@ rtl/u2u8_front.sv @@
// Front end: takes code units, pairs surrogates and queues byte-forming requests.
module u2u8_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [15:0] code_unit
    input  logic               s_tlast,   // last_unit
    input  logic               q_full,
    output logic               q_push,
    output u2u8_pkg::entry_t   q_wdata
);

    logic        pend_reg, pend_next;
    logic [9:0]  hbits_reg, hbits_next;
    logic        accept;
    logic        is_high, is_low;
    logic [20:0] pair_cp;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (s_tdata >= u2u8_pkg::HIGH_MIN) && (s_tdata <= u2u8_pkg::HIGH_MAX);
    assign is_low   = (s_tdata >= u2u8_pkg::LOW_MIN) && (s_tdata <= u2u8_pkg::LOW_MAX);
    assign pair_cp  = u2u8_pkg::SUPP_BASE + {1'b0, hbits_reg, s_tdata[9:0]};

    always_comb
    begin
        q_wdata.pre  = pend_reg && !is_low;
        q_wdata.last = s_tlast;
        q_wdata.cp   = {5'b00000, s_tdata};
        q_wdata.len  = u2u8_pkg::cp_len({5'b00000, s_tdata});
        if (pend_reg && is_low)
        begin
            q_wdata.cp  = pair_cp;
            q_wdata.len = u2u8_pkg::LEN_4;
        end
        else if (is_high && !s_tlast)
        begin
            q_wdata.len = u2u8_pkg::LEN_NONE;
        end
        else if (is_high || is_low)
        begin
            q_wdata.cp  = u2u8_pkg::REPL_CP;
            q_wdata.len = u2u8_pkg::LEN_3;
        end
        q_push = accept && (q_wdata.pre || (q_wdata.len != u2u8_pkg::LEN_NONE));

        pend_next  = pend_reg;
        hbits_next = hbits_reg;
        if (accept)
        begin
            pend_next  = is_high && !s_tlast;
            hbits_next = s_tdata[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            hbits_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            hbits_reg <= hbits_next;
        end
    end

endmodule

@@ rtl/u2u8_queue.sv @@
// Request queue between the front and back ends.
`include "utf16_to_utf8_encoder_macros.svh"

module u2u8_queue
#(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u2u8_pkg::entry_t   wdata,
    output logic               full,
    input  logic               pop,
    output logic               rvalid,
    output u2u8_pkg::entry_t   rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    u2u8_pkg::entry_t mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_FULL);
    assign rvalid = (count_reg != '0);
    assign rdata  = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `U2U8_ASSERT_IMP(a_no_overflow, clk, rst_n, full, !push)
    `U2U8_ASSERT_IMP(a_no_underflow, clk, rst_n, !rvalid, !pop)
    `U2U8_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ rtl/u2u8_back.sv @@
// Back end: turns queued requests into UTF-8 bytes behind an output register.
`include "utf16_to_utf8_encoder_macros.svh"

module u2u8_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  u2u8_pkg::entry_t   q_rdata,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic               m_tlast,   // run_last
    output logic               m_tuser    // string_end
);

    logic             busy_reg, busy_next;
    u2u8_pkg::entry_t ent_reg, ent_next;
    logic [2:0]       idx_reg, idx_next;
    logic             mval_reg, mval_next;
    logic [7:0]       byte_reg, byte_next;
    logic             rlast_reg, rlast_next;
    logic             send_reg, send_next;

    logic             load;
    logic [2:0]       pre_n, total, j;
    logic             last_byte;
    logic [7:0]       cur_byte;

    assign pre_n     = ent_reg.pre ? 3'd3 : 3'd0;
    assign total     = pre_n + ent_reg.len;
    assign last_byte = (idx_reg == total - 3'd1);
    assign j         = idx_reg - pre_n;
    assign load      = !mval_reg || m_tready;

    always_comb
    begin
        if (ent_reg.pre && (idx_reg < 3'd3))
            cur_byte = u2u8_pkg::utf8_byte(u2u8_pkg::REPL_CP, u2u8_pkg::LEN_3, idx_reg[1:0]);
        else
            cur_byte = u2u8_pkg::utf8_byte(ent_reg.cp, ent_reg.len, j[1:0]);
    end

    always_comb
    begin
        q_pop      = 1'b0;
        busy_next  = busy_reg;
        ent_next   = ent_reg;
        idx_next   = idx_reg;
        mval_next  = mval_reg && !m_tready;
        byte_next  = byte_reg;
        rlast_next = rlast_reg;
        send_next  = send_reg;
        if (busy_reg && load)
        begin
            mval_next  = 1'b1;
            byte_next  = cur_byte;
            rlast_next = last_byte;
            send_next  = last_byte && ent_reg.last;
            if (last_byte)
            begin
                idx_next  = '0;
                busy_next = q_valid;
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ent_next = q_rdata;
                end
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (!busy_reg && q_valid)
        begin
            q_pop     = 1'b1;
            busy_next = 1'b1;
            ent_next  = q_rdata;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mval_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mval_reg <= mval_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        byte_reg  <= byte_next;
        rlast_reg <= rlast_next;
        send_reg  <= send_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = rlast_reg;
    assign m_tuser  = send_reg;

    `U2U8_ASSERT_IMP(a_end_on_last, clk, rst_n, m_tvalid && m_tuser, m_tlast)
    `U2U8_ASSERT_IMP(a_idx_in_run, clk, rst_n, busy_reg, idx_reg < total)
    `U2U8_ASSERT_IMP(a_pop_when_free, clk, rst_n, q_pop, !busy_reg || (load && last_byte))

endmodule

@@ rtl/utf16_to_utf8_encoder.sv @@
// Path: each request is queued, loaded by the back end, then sent via its output register.
// Throughput: one byte per cycle while m_tready is high and requests wait; a unit yields
// 0 to 6 bytes; the rate is set by the single byte-wide output register of the back end.
// Input is taken whenever the request queue between front and back ends has room.
// Reset (rst_n low, asynchronous) drops any held high surrogate and empties queue and output.
// Top level: streaming UTF-16 to UTF-8 encoder.
module utf16_to_utf8_encoder
#(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // string_end
);

    logic             q_full, q_push, q_valid, q_pop;
    u2u8_pkg::entry_t q_wdata, q_rdata;

    u2u8_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    u2u8_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    u2u8_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
